// ===== rtl/bdq_pkg.sv =====
// bdq_pkg: shared constants, types and action codes of the bounded deque
// used by the channel interfaces, the deque top level and its checker
package bdq_pkg;

  localparam int DEPTH    = 16;
  localparam int ACT_W    = 3;
  localparam int ITEM_W   = 32;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int OCC_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CMP_W    = (OCC_W > POS_W) ? OCC_W : POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_REMOVE_AT  = 3'd6
  } act_t;

endpackage

// ===== rtl/bdq_req_if.sv =====
// bdq_req_if: request channel of the bounded deque (valid, ready, request word)
// depends on bdq_pkg for field widths
interface bdq_req_if import bdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ITEM_W-1:0] item;
  logic [POS_W-1:0]  position;

  modport source (output valid, action, item, position, input ready);
  modport sink   (input valid, action, item, position, output ready);
endinterface

// ===== rtl/bdq_res_if.sv =====
// bdq_res_if: result channel of the bounded deque (valid, ready, result word)
// depends on bdq_pkg for field widths
interface bdq_res_if import bdq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [ITEM_W-1:0]  item_out;
  logic [COUNT_W-1:0] count;
  logic               empty_res;

  modport source (output valid, ok, item_out, count, empty_res, input ready);
  modport sink   (input valid, ok, item_out, count, empty_res, output ready);
endinterface

// ===== rtl/bounded_deque_with_remove_at.sv =====
// bounded_deque_with_remove_at: deque of DEPTH words with push, pop, peek and
// remove at position; depends on bdq_pkg, bdq_req_if and bdq_res_if
// the result word is registered and valid in the cycle after its request word is accepted
// throughput: one word per cycle; the store is a register file updated in one
// shift pass, and the result register stalls the request side only when full
// reset: occupancy and result valid cleared; stored words are not cleared
module bounded_deque_with_remove_at import bdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  bdq_req_if.sink   req,
  bdq_res_if.source res
);

  logic [ITEM_W-1:0]  store      [DEPTH];
  logic [ITEM_W-1:0]  store_next [DEPTH];
  logic [OCC_W-1:0]   occ;
  logic [OCC_W-1:0]   occ_next;

  logic               res_valid;
  logic               res_ok;
  logic [ITEM_W-1:0]  res_item;
  logic [COUNT_W-1:0] res_count;
  logic               res_empty;

  logic               accept;
  logic               ok;
  logic               reads;
  logic               shift_down;
  logic [IDX_W-1:0]   sh_from;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   back_idx;
  logic [IDX_W-1:0]   rm_idx;
  logic [CMP_W-1:0]   pos_c;
  logic [CMP_W-1:0]   occ_c;
  logic [CMP_W-1:0]   occ_next_c;
  logic               full;
  logic               is_empty;
  logic               pos_ok;
  logic [ITEM_W-1:0]  rd_data;

  assign req.ready = !res_valid || res.ready;
  assign accept    = req.valid && req.ready;

  assign full      = (occ == OCC_W'(DEPTH));
  assign is_empty  = (occ == '0);
  assign back_idx  = IDX_W'(occ - OCC_W'(1));
  assign pos_c     = CMP_W'(req.position);
  assign occ_c     = CMP_W'(occ);
  assign pos_ok    = (pos_c != '0) && (pos_c <= occ_c);
  assign rm_idx    = IDX_W'(pos_c - CMP_W'(1));
  assign rd_data   = store[rd_idx];

  always_comb begin
    occ_next   = occ;
    ok         = 1'b0;
    reads      = 1'b0;
    shift_down = 1'b0;
    sh_from    = '0;
    rd_idx     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      store_next[i] = store[i];
    end
    case (act_t'(req.action))
      ACT_PUSH_FRONT: begin
        if (!full) begin
          ok = 1'b1;
          occ_next = occ + OCC_W'(1);
          store_next[0] = req.item;
          for (int i = 1; i < DEPTH; i++) begin
            store_next[i] = store[i-1];
          end
        end
      end
      ACT_PUSH_BACK: begin
        if (!full) begin
          ok = 1'b1;
          occ_next = occ + OCC_W'(1);
          store_next[IDX_W'(occ)] = req.item;
        end
      end
      ACT_POP_FRONT: begin
        if (!is_empty) begin
          ok = 1'b1;
          reads = 1'b1;
          shift_down = 1'b1;
          occ_next = occ - OCC_W'(1);
        end
      end
      ACT_POP_BACK: begin
        rd_idx = back_idx;
        if (!is_empty) begin
          ok = 1'b1;
          reads = 1'b1;
          occ_next = occ - OCC_W'(1);
        end
      end
      ACT_PEEK_FRONT: begin
        if (!is_empty) begin
          ok = 1'b1;
          reads = 1'b1;
        end
      end
      ACT_PEEK_BACK: begin
        rd_idx = back_idx;
        if (!is_empty) begin
          ok = 1'b1;
          reads = 1'b1;
        end
      end
      ACT_REMOVE_AT: begin
        rd_idx  = rm_idx;
        sh_from = rm_idx;
        if (pos_ok) begin
          ok = 1'b1;
          reads = 1'b1;
          shift_down = 1'b1;
          occ_next = occ - OCC_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (shift_down) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IDX_W'(i) >= sh_from) begin
          store_next[i] = store[i+1];
        end
      end
    end
  end

  assign occ_next_c = CMP_W'(occ_next);

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < DEPTH; i++) begin
        store[i] <= store_next[i];
      end
      res_ok    <= ok;
      res_item  <= reads ? rd_data : '0;
      res_count <= occ_next_c[COUNT_W-1:0];
      res_empty <= (occ_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        occ <= occ_next;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign res.valid     = res_valid;
  assign res.ok        = res_ok;
  assign res.item_out  = res_item;
  assign res.count     = res_count;
  assign res.empty_res = res_empty;

endmodule

// ===== rtl/bdq_checker.sv =====
// bdq_checker: port-level assertions on the bounded deque result channel
// depends on bdq_pkg; bound to bounded_deque_with_remove_at below
module bdq_checker import bdq_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic               res_ok,
  input logic [ITEM_W-1:0]  res_item_out,
  input logic [COUNT_W-1:0] res_count,
  input logic               res_empty_res
);

  localparam int CNT_CMP_W = (COUNT_W > OCC_W) ? COUNT_W : OCC_W;

  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_empty_res == (res_count == '0)))
    else $error("empty flag disagrees with count");

  a_failed_word_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ok) |-> (res_item_out == '0))
    else $error("failed request returned a nonzero word");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (CNT_CMP_W'(res_count) <= CNT_CMP_W'(DEPTH)))
    else $error("count above capacity");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_item_out)
                                   && $stable(res_count) && $stable(res_ok)))
    else $error("stalled result word changed");

endmodule

bind bounded_deque_with_remove_at bdq_checker u_bdq_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_ok        (res.ok),
  .res_item_out  (res.item_out),
  .res_count     (res.count),
  .res_empty_res (res.empty_res)
);
